/* rtl/core/htok_pkg.sv */
// Package for the HTTP request tokenizer.
// Holds field widths, character codes, phase/kind/action types and the result struct.
// No dependencies.
package htok_pkg;

    localparam int DATA_W = 8;
    localparam int POS_W  = 12;
    localparam int KIND_W = 3;

    localparam logic [DATA_W-1:0] CH_NUL = 8'h00;
    localparam logic [DATA_W-1:0] CH_LF  = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR  = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SP  = 8'h20;

    localparam logic [POS_W-1:0] FIELD_MAX = {POS_W{1'b1}};

    // Parse phase; codes 5 to 7 are never entered and end the request
    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_TARGET   = 3'd1,
        PH_VERSION  = 3'd2,
        PH_HEADER   = 3'd3,
        PH_AFTER_LF = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_METHOD  = 3'd0,
        KIND_TARGET  = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_HEADER  = 3'd3,
        KIND_END     = 3'd4
    } t_kind;

    // What one byte does to the parser
    typedef enum logic [1:0] {
        ACT_SKIP   = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   length;
        logic               done;
    } t_token;

    // Handshake between parser and output stage
    typedef struct packed {
        logic   load;
        logic   free;
    } t_out_ctl;

endpackage

/* rtl/core/htok_if.sv */
// Channel interfaces of the HTTP request tokenizer: byte requests in, tokens out.
// Depends on htok_pkg for widths.
interface htok_byte_if;
    logic                               valid;
    logic                               ready;
    logic [htok_pkg::DATA_W-1:0]        data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface htok_token_if;
    logic                               valid;
    logic                               ready;
    logic [htok_pkg::KIND_W-1:0]        token_kind;
    logic [htok_pkg::POS_W-1:0]         token_start;
    logic [htok_pkg::POS_W-1:0]         token_length;
    logic                               request_done;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output request_done, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input request_done, output ready);
endinterface

/* rtl/core/htok_in_stage.sv */
// Input register of the tokenizer: holds one byte request until the parser takes it.
// Depends on htok_pkg.
module htok_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [htok_pkg::DATA_W-1:0] i_data_byte,
    output logic                        o_ready,
    input  logic                        i_consume,
    output logic                        o_valid,
    output logic [htok_pkg::DATA_W-1:0] o_data_byte
);
    import htok_pkg::*;

    logic                r_valid;
    logic [DATA_W-1:0]   r_byte;
    logic                n_valid;
    logic                w_load;

    // Take a new byte when empty or when the held one moves on
    assign o_ready = !r_valid || i_consume;
    assign w_load  = i_valid && o_ready;
    assign n_valid = w_load || (r_valid && !i_consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;

endmodule

/* rtl/core/htok_parser.sv */
// Parser core: phase, position, token origin and length registers, plus byte decode.
// Depends on htok_pkg.
module htok_parser #(
    parameter int MAX_REQUEST_BYTES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [htok_pkg::DATA_W-1:0] i_data_byte,
    input  htok_pkg::t_out_ctl          i_out_ctl,
    output logic                        o_consume,
    output htok_pkg::t_out_ctl          o_out_ctl,
    output htok_pkg::t_token            o_token
);
    import htok_pkg::*;

    localparam int PosLimitInt = (MAX_REQUEST_BYTES - 1 > int'(FIELD_MAX)) ?
                                 int'(FIELD_MAX) : MAX_REQUEST_BYTES - 1;
    localparam logic [POS_W-1:0] PosLimit = POS_W'(PosLimitInt);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_origin, n_origin;
    logic [POS_W-1:0]   r_len, n_len;

    t_phase             w_eff;
    t_action            w_act;
    logic [POS_W-1:0]   w_pos_inc;
    logic               w_produce;

    // Byte just after a header LF that is not CR, LF or zero opens a header line
    assign w_eff     = (r_phase == PH_AFTER_LF) ? PH_HEADER : r_phase;
    assign w_pos_inc = (r_pos >= PosLimit) ? PosLimit : r_pos + POS_W'(1);

    // Decode the byte into one action
    always_comb begin
        w_act = ACT_FINISH;
        priority if (r_phase == PH_AFTER_LF && i_data_byte == CH_CR) begin
            w_act = ACT_SKIP;
        end else if (r_phase == PH_AFTER_LF && i_data_byte == CH_LF) begin
            w_act = ACT_FINISH;
        end else if (i_data_byte == CH_NUL) begin
            w_act = ACT_FINISH;
        end else if (w_eff == PH_METHOD || w_eff == PH_TARGET) begin
            w_act = (i_data_byte == CH_SP) ? ACT_CLOSE : ACT_COUNT;
        end else if (w_eff == PH_VERSION || w_eff == PH_HEADER) begin
            if (i_data_byte == CH_CR) begin
                w_act = ACT_SKIP;
            end else if (i_data_byte == CH_LF) begin
                w_act = ACT_CLOSE;
            end else begin
                w_act = ACT_COUNT;
            end
        end else begin
            w_act = ACT_FINISH;
        end
    end

    // Advance unless a result is due and the output stage is full
    assign w_produce = (w_act == ACT_CLOSE) || (w_act == ACT_FINISH);
    assign o_consume = i_valid && (!w_produce || i_out_ctl.free);
    assign o_out_ctl.load = o_consume && w_produce;
    assign o_out_ctl.free = 1'b0;

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_origin = r_origin;
        n_len    = r_len;
        if (o_consume) begin
            unique case (w_act)
                ACT_SKIP: begin
                    n_pos = w_pos_inc;
                end
                ACT_COUNT: begin
                    n_phase = w_eff;
                    n_pos   = w_pos_inc;
                    n_len   = (r_len < FIELD_MAX) ? r_len + POS_W'(1) : r_len;
                end
                ACT_CLOSE: begin
                    n_pos    = w_pos_inc;
                    n_origin = w_pos_inc;
                    n_len    = '0;
                    unique case (w_eff)
                        PH_METHOD:  n_phase = PH_TARGET;
                        PH_TARGET:  n_phase = PH_VERSION;
                        PH_VERSION: n_phase = PH_HEADER;
                        default:    n_phase = PH_AFTER_LF;
                    endcase
                end
                default: begin
                    n_phase  = PH_METHOD;
                    n_pos    = '0;
                    n_origin = '0;
                    n_len    = '0;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        o_token.start  = r_origin;
        o_token.length = r_len;
        o_token.done   = 1'b0;
        unique case (w_eff)
            PH_METHOD:  o_token.kind = KIND_METHOD;
            PH_TARGET:  o_token.kind = KIND_TARGET;
            PH_VERSION: o_token.kind = KIND_VERSION;
            default:    o_token.kind = KIND_HEADER;
        endcase
        if (w_act == ACT_FINISH) begin
            o_token.kind   = KIND_END;
            o_token.start  = r_pos;
            o_token.length = '0;
            o_token.done   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_METHOD;
            r_pos    <= '0;
            r_origin <= '0;
            r_len    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_len    <= n_len;
        end
    end

endmodule

/* rtl/core/htok_out_stage.sv */
// Output register of the tokenizer: holds one token until the receiver takes it.
// Depends on htok_pkg.
module htok_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  htok_pkg::t_out_ctl  i_ctl,
    input  htok_pkg::t_token    i_token,
    output htok_pkg::t_out_ctl  o_ctl,
    output logic                o_valid,
    input  logic                i_ready,
    output htok_pkg::t_token    o_token
);
    import htok_pkg::*;

    logic    r_valid, n_valid;
    t_token  r_token;

    // Free when empty or being drained this cycle
    assign o_ctl.free = !r_valid || i_ready;
    assign o_ctl.load = i_ctl.load;
    assign n_valid    = i_ctl.load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_token <= i_token;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

/* rtl/core/http_request_tokenizer_top.sv */
// HTTP request tokenizer.
// Channels: i_req carries one request byte per handshake (valid/ready, data_byte); a zero
// byte marks the end of the buffer. o_tok carries tokens: token_kind (0 method, 1 target,
// 2 version, 3 header line, 4 end of request), token_start, token_length, request_done.
// A byte produces zero or one token.
// Throughput: one byte per cycle while o_tok is ready; the parser state update is a single
// compare-and-increment step, so a byte can follow in every cycle.
// Path: an accepted byte passes the input register, then its token the output register, before o_tok.
// Stall: the input register takes one more byte while a token waits on o_tok; bytes that
// produce no token keep flowing; a byte that ends a token waits in the input register.
// Reset (i_rst_n low, synchronous): both stages empty, parser back to the method phase at
// offset zero. After each end-of-request token the parser restarts the same way.
// Offsets saturate at min(MAX_REQUEST_BYTES - 1, 4095); lengths saturate at 4095.
// Depends on htok_pkg, htok_if, htok_in_stage, htok_parser, htok_out_stage.
module http_request_tokenizer_top #(
    parameter int MAX_REQUEST_BYTES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    htok_byte_if.sink       i_req,
    htok_token_if.source    o_tok
);
    import htok_pkg::*;

    logic                w_in_valid;
    logic [DATA_W-1:0]   w_in_byte;
    logic                w_consume;
    t_out_ctl            w_load_ctl;
    t_out_ctl            w_free_ctl;
    t_token              w_token;
    t_token              w_out_token;

    htok_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_data_byte (i_req.data_byte),
        .o_ready     (i_req.ready),
        .i_consume   (w_consume),
        .o_valid     (w_in_valid),
        .o_data_byte (w_in_byte)
    );

    htok_parser #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_data_byte (w_in_byte),
        .i_out_ctl   (w_free_ctl),
        .o_consume   (w_consume),
        .o_out_ctl   (w_load_ctl),
        .o_token     (w_token)
    );

    htok_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_load_ctl),
        .i_token (w_token),
        .o_ctl   (w_free_ctl),
        .o_valid (o_tok.valid),
        .i_ready (o_tok.ready),
        .o_token (w_out_token)
    );

    // Drive the token channel payload
    assign o_tok.token_kind   = w_out_token.kind;
    assign o_tok.token_start  = w_out_token.start;
    assign o_tok.token_length = w_out_token.length;
    assign o_tok.request_done = w_out_token.done;

endmodule

/* rtl/core/htok_checker.sv */
// Port-level checks for the HTTP request tokenizer, bound to the top level.
// Depends on htok_pkg and http_request_tokenizer_top.
module htok_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [htok_pkg::KIND_W-1:0] i_kind,
    input  logic [htok_pkg::POS_W-1:0]  i_start,
    input  logic [htok_pkg::POS_W-1:0]  i_length,
    input  logic                        i_done
);
    import htok_pkg::*;

    // Hold a stalled token
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) &&
        $stable(i_start) && $stable(i_length) && $stable(i_done))
        else $error("token changed while stalled");

    // Done flag marks exactly the end-of-request kind
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_done == (i_kind == KIND_END)))
        else $error("request_done disagrees with token_kind");

    // End of request carries no length
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> i_length == '0)
        else $error("end of request with nonzero length");

    // An empty output stage never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind http_request_tokenizer_top htok_checker u_htok_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_tok.valid),
    .i_out_ready (o_tok.ready),
    .i_kind      (o_tok.token_kind),
    .i_start     (o_tok.token_start),
    .i_length    (o_tok.token_length),
    .i_done      (o_tok.request_done)
);

/* test/http_request_tokenizer_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the HTTP request tokenizer: watches the byte and token channels,
// tracks the tokenizer state itself and compares every token field by field.
// Depends on htok_pkg and htok_if.
module http_request_tokenizer_checker #(
    parameter int MAX_REQUEST_BYTES = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    htok_byte_if    i_req,
    htok_token_if   i_tok,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_token_count
);
    import htok_pkg::*;

    // Offsets stop at the buffer end or at the field maximum, whichever comes first
    localparam logic [POS_W-1:0] POS_CAP = (MAX_REQUEST_BYTES - 1 > int'(FIELD_MAX)) ?
                                           FIELD_MAX : POS_W'(MAX_REQUEST_BYTES - 1);

    t_phase             phase_q;
    logic [POS_W-1:0]   pos_q;
    logic [POS_W-1:0]   origin_q;
    logic [POS_W-1:0]   run_len_q;
    t_token             expected_tokens[$];

    function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0] p);
        return (p >= POS_CAP) ? POS_CAP : p + 1'b1;
    endfunction

    task automatic restart_request();
        phase_q   = PH_METHOD;
        pos_q     = '0;
        origin_q  = '0;
        run_len_q = '0;
    endtask

    task automatic emit_token(input t_kind kind, input logic [POS_W-1:0] start,
                              input logic [POS_W-1:0] len, input logic done);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = len;
        t.done   = done;
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    // Report the open token and open the next one after the delimiter
    task automatic close_token(input t_kind kind, input t_phase next_phase);
        emit_token(kind, origin_q, run_len_q, 1'b0);
        origin_q  = advance_pos(pos_q);
        run_len_q = '0;
        phase_q   = next_phase;
        pos_q     = advance_pos(pos_q);
    endtask

    // End of request: report the ending byte's offset and start over
    task automatic end_request();
        emit_token(KIND_END, pos_q, '0, 1'b1);
        restart_request();
    endtask

    task automatic count_byte();
        if (run_len_q < FIELD_MAX) begin
            run_len_q = run_len_q + 1'b1;
        end
        pos_q = advance_pos(pos_q);
    endtask

    task automatic tokenize_byte(input logic [DATA_W-1:0] b);
        // Right after a header LF: CR is skipped, LF ends the request
        if (phase_q == PH_AFTER_LF) begin
            if (b == CH_CR) begin
                pos_q = advance_pos(pos_q);
                return;
            end
            if (b == CH_LF) begin
                end_request();
                return;
            end
            phase_q = PH_HEADER;
        end
        if (b == CH_NUL) begin
            end_request();
        end else if (phase_q == PH_METHOD) begin
            if (b == CH_SP) close_token(KIND_METHOD, PH_TARGET);
            else count_byte();
        end else if (phase_q == PH_TARGET) begin
            if (b == CH_SP) close_token(KIND_TARGET, PH_VERSION);
            else count_byte();
        end else if (b == CH_CR) begin
            pos_q = advance_pos(pos_q);
        end else if (b == CH_LF) begin
            if (phase_q == PH_VERSION) close_token(KIND_VERSION, PH_HEADER);
            else close_token(KIND_HEADER, PH_AFTER_LF);
        end else begin
            count_byte();
        end
    endtask

    // Compare one delivered token with the oldest expectation
    task automatic check_token();
        t_token exp;
        o_token_count++;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token kind=%0d start=%0d length=%0d done=%0b",
                     $time, i_tok.token_kind, i_tok.token_start, i_tok.token_length,
                     i_tok.request_done);
            o_fail_count++;
            return;
        end
        exp = expected_tokens.pop_front();
        if (i_tok.token_kind !== exp.kind) begin
            $display("%0t: token_kind mismatch: expected %0d, got %0d",
                     $time, exp.kind, i_tok.token_kind);
            o_fail_count++;
        end
        if (i_tok.token_start !== exp.start) begin
            $display("%0t: token_start mismatch: expected %0d, got %0d",
                     $time, exp.start, i_tok.token_start);
            o_fail_count++;
        end
        if (i_tok.token_length !== exp.length) begin
            $display("%0t: token_length mismatch: expected %0d, got %0d",
                     $time, exp.length, i_tok.token_length);
            o_fail_count++;
        end
        if (i_tok.request_done !== exp.done) begin
            $display("%0t: request_done mismatch: expected %0b, got %0b",
                     $time, exp.done, i_tok.request_done);
            o_fail_count++;
        end
    endtask

    // Check delivered tokens, then predict from accepted bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_request();
            expected_tokens.delete();
            o_fail_count  = 0;
            o_token_count = 0;
        end else begin
            if (i_tok.valid && i_tok.ready) check_token();
            if (i_req.valid && i_req.ready) tokenize_byte(i_req.data_byte);
        end
        o_pending = expected_tokens.size();
    end

endmodule

/* test/http_request_tokenizer_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the HTTP request tokenizer: clock, reset, request byte stimulus
// and token-side back-pressure; checking is done by http_request_tokenizer_checker.
// Depends on htok_pkg, htok_if, http_request_tokenizer_top and the checker.
module http_request_tokenizer_top_tb;
    import htok_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 12;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASE_BYTES      = 50;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_TOKEN_BYTES = 32;
    localparam int MAX_GAP          = 16;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic               i_clk;
    logic               i_rst_n;
    htok_byte_if        req_ch();
    htok_token_if       tok_ch();

    logic [DATA_W-1:0]  stream_bytes[$];
    t_idle_mode         idle_mode = IDLE_NONE;
    bit                 long_hold_start = 1'b0;
    int                 hold_left = 0;
    int                 bytes_sent = 0;
    int                 chk_fail_count;
    int                 chk_pending;
    int                 chk_token_count;

    http_request_tokenizer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_tok   (tok_ch)
    );

    http_request_tokenizer_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_tok         (tok_ch),
        .o_fail_count  (chk_fail_count),
        .o_pending     (chk_pending),
        .o_token_count (chk_token_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 58;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 58;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // Token sink: a long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (long_hold_start) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            tok_ch.ready <= 1'b0;
        end else begin
            tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct());
        end
    end

    task automatic add_byte(input logic [DATA_W-1:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic add_eol();
        if ($urandom_range(1)) add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    // Mostly printable text; now and then any byte that keeps the token open
    function automatic logic [DATA_W-1:0] body_byte(input bit in_request_line);
        logic [DATA_W-1:0] b;
        if ($urandom_range(7) != 0) begin
            b = DATA_W'($urandom_range(8'h7E, 8'h21));
        end else begin
            b = DATA_W'($urandom_range(255, 1));
            if (in_request_line ? (b == CH_SP) : (b == CH_LF)) b = 8'h7E;
        end
        return b;
    endfunction

    // Build one request: mostly well formed, some cut short by a zero byte, some noise
    task automatic add_request();
        int shape;
        int first;
        int n;
        int line_len;
        first = stream_bytes.size();
        shape = $urandom_range(99);
        if (shape < 10) begin
            n = $urandom_range(20, 1);
            repeat (n) add_byte(DATA_W'($urandom_range(255, 0)));
            add_byte(CH_NUL);
            return;
        end
        // method in capitals, then target
        n = $urandom_range(6, 0);
        repeat (n) add_byte(DATA_W'($urandom_range(8'h5A, 8'h41)));
        add_byte(CH_SP);
        n = $urandom_range(16, 0);
        repeat (n) add_byte(body_byte(1'b1));
        add_byte(CH_SP);
        add_text("HTTP/1.");
        add_byte(DATA_W'(8'h30 + $urandom_range(9)));
        add_eol();
        n = $urandom_range(4, 0);
        repeat (n) begin
            line_len = $urandom_range(24, 1);
            repeat (line_len) add_byte(body_byte(1'b0));
            add_eol();
        end
        // with no header lines, an empty header line comes first
        if (n == 0) add_eol();
        if ($urandom_range(4) == 0) add_byte(CH_NUL);
        else add_eol();
        // cut short: drop the tail and end with a zero byte
        if (shape < 25) begin
            n = $urandom_range(stream_bytes.size() - 1, first);
            while (stream_bytes.size() > n) void'(stream_bytes.pop_back());
            add_byte(CH_NUL);
        end
    endtask

    // Offer queued bytes one per request, with random gaps in front
    task automatic send_stream();
        logic [DATA_W-1:0] b;
        int gap;
        while (stream_bytes.size() > 0) begin
            b = stream_bytes.pop_front();
            gap = 0;
            while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct()) gap++;
            repeat (gap) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
            end
            @(negedge i_clk);
            req_ch.valid     <= 1'b1;
            req_ch.data_byte <= b;
            do @(posedge i_clk); while (!req_ch.ready);
            bytes_sent++;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (chk_pending != 0);
    endtask

    // Run out of cycles: give up
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d tokens outstanding", CYCLE_LIMIT, chk_pending);
        $display("[http_request_tokenizer_top] ERROR");
        $finish;
    end

    initial begin
        t_idle_mode phase_modes[4];
        phase_modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data_byte = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty request, CR/LF and 0xFF in the method, empty target,
        // CR in the version, CR right after a header LF, blank-line end,
        // zero byte inside a token, zero byte right after a header LF
        add_byte(CH_NUL);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(8'hFF);
        add_byte(CH_SP);
        add_byte(CH_SP);
        add_text("H");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("k");
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_text("z");
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("A");
        add_byte(CH_NUL);
        add_byte(CH_SP);
        add_byte(CH_SP);
        add_byte(CH_LF);
        add_text("q");
        add_byte(CH_LF);
        add_byte(CH_NUL);
        send_stream();
        wait_drained();

        // Random requests under each idle mix; pause until drained between them
        foreach (phase_modes[m]) begin
            idle_mode = phase_modes[m];
            while (stream_bytes.size() < PHASE_BYTES) add_request();
            send_stream();
            wait_drained();
        end

        // Hold the token side off while short header lines keep coming
        idle_mode = IDLE_NONE;
        long_hold_start = 1'b1;
        add_text("GET / HTTP/1.1");
        add_byte(CH_LF);
        repeat (40) begin
            add_text("h");
            add_byte(CH_LF);
        end
        add_byte(CH_LF);
        send_stream();
        wait_drained();

        // Long method with CRLF line ends, then a fresh request right behind it
        repeat (LONG_TOKEN_BYTES) add_byte(8'h41);
        add_text(" /x HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("k: v");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("PUT /y HTTP/1.0");
        add_byte(CH_LF);
        add_byte(CH_LF);
        add_byte(CH_NUL);
        send_stream();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d request bytes, checked %0d tokens over directed cases, four idle",
                 bytes_sent, chk_token_count);
        $display("mixes, a long token-side stall and back-to-back CRLF requests.");
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("[http_request_tokenizer_top] OK");
        end else begin
            $display("%0d mismatches, %0d tokens never delivered", chk_fail_count, chk_pending);
            $display("[http_request_tokenizer_top] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/htok_pkg.sv
rtl/core/htok_if.sv
rtl/core/htok_in_stage.sv
rtl/core/htok_parser.sv
rtl/core/htok_out_stage.sv
rtl/core/http_request_tokenizer_top.sv
rtl/core/htok_checker.sv
test/http_request_tokenizer_checker.sv
test/http_request_tokenizer_top_tb.sv
